/* sv/srd_pkg.sv */
// Package for the signed restoring divider: widths, request and response
// payload types, and the record that travels down the divider pipeline.
// No dependencies.
package srd_pkg;

   localparam int WIDTH_BYTES   = 4;
   localparam int BITS_PER_BYTE = 8;
   localparam int DATA_W        = WIDTH_BYTES * BITS_PER_BYTE;
   localparam int QBITS_W       = 6;
   localparam int LEN_W         = 7;
   localparam int QBITS_MAX     = 63;

   typedef struct packed {
      logic signed [DATA_W-1:0] dividend;
      logic signed [DATA_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quotient;
      logic [QBITS_W-1:0]       quotient_bits;
      logic                     divide_by_zero;
   } rsp_type;

   // Partial remainder, dividend bits still to be consumed (shifted out at
   // the top) with quotient bits shifted in at the bottom, divisor magnitude,
   // result sign and the zero-divisor flag.
   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] aq;
      logic [DATA_W-1:0] nb;
      logic              neg;
      logic              dz;
   } stage_type;

endpackage

/* sv/srd_prep.sv */
// Input stage of the signed restoring divider: takes operand magnitudes,
// the result sign and the zero-divisor flag into the first pipeline register.
// Depends on srd_pkg.
module srd_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  srd_pkg::req_type    in_data,
   output logic                out_valid_ff,
   output srd_pkg::stage_type  out_data_ff
);

   logic [srd_pkg::DATA_W-1:0] a;
   logic [srd_pkg::DATA_W-1:0] b;
   srd_pkg::stage_type         out_data_in;

   always_comb begin
      a = in_data.dividend;
      b = in_data.divisor;
      out_data_in.rem = '0;
      out_data_in.aq  = a[srd_pkg::DATA_W-1] ? ({srd_pkg::DATA_W{1'b0}} - a) : a;
      out_data_in.nb  = b[srd_pkg::DATA_W-1] ? ({srd_pkg::DATA_W{1'b0}} - b) : b;
      out_data_in.neg = a[srd_pkg::DATA_W-1] ^ b[srd_pkg::DATA_W-1];
      out_data_in.dz  = (b == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= in_valid;
      end
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

/* sv/srd_div_stage.sv */
// One restoring division step: shifts in the next dividend bit, compares
// against the divisor magnitude and keeps or restores the partial remainder.
// Depends on srd_pkg.
module srd_div_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  srd_pkg::stage_type  in_data,
   output logic                out_valid_ff,
   output srd_pkg::stage_type  out_data_ff
);

   logic [srd_pkg::DATA_W:0] shifted;
   logic [srd_pkg::DATA_W:0] diff;
   logic                     take;
   srd_pkg::stage_type       out_data_in;

   always_comb begin
      shifted     = {in_data.rem, in_data.aq[srd_pkg::DATA_W-1]};
      diff        = shifted - {1'b0, in_data.nb};
      take        = (shifted >= {1'b0, in_data.nb});
      out_data_in = in_data;
      out_data_in.rem = take ? diff[srd_pkg::DATA_W-1:0] : shifted[srd_pkg::DATA_W-1:0];
      out_data_in.aq  = {in_data.aq[srd_pkg::DATA_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= in_valid;
      end
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

/* sv/srd_post.sv */
// Output stages of the signed restoring divider: applies the result sign,
// then finds the minimal two's complement bit length into the response register.
// Depends on srd_pkg.
module srd_post (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  srd_pkg::stage_type  in_data,
   output logic                out_valid_ff,
   output srd_pkg::rsp_type    out_data_ff
);

   logic                       sgn_valid_ff;
   logic [srd_pkg::DATA_W-1:0] sgn_q_ff;
   logic [srd_pkg::DATA_W-1:0] sgn_q_in;
   logic                       sgn_dz_ff;
   logic [srd_pkg::DATA_W-1:0] v;
   logic [srd_pkg::LEN_W-1:0]  len;
   logic [srd_pkg::LEN_W-1:0]  bits;
   srd_pkg::rsp_type           out_data_in;

   assign sgn_q_in = in_data.neg ? ({srd_pkg::DATA_W{1'b0}} - in_data.aq) : in_data.aq;

   always_comb begin
      v   = sgn_q_ff[srd_pkg::DATA_W-1] ? ~sgn_q_ff : sgn_q_ff;
      len = '0;
      for (int i = 0; i < srd_pkg::DATA_W; i++) begin
         if (v[i]) begin
            len = srd_pkg::LEN_W'(i + 1);
         end
      end
      bits = len + 1'b1;
      if (bits > srd_pkg::LEN_W'(srd_pkg::QBITS_MAX)) begin
         bits = srd_pkg::LEN_W'(srd_pkg::QBITS_MAX);
      end
      if (sgn_dz_ff || (sgn_q_ff == '0)) begin
         out_data_in.quotient      = '0;
         out_data_in.quotient_bits = '0;
      end else begin
         out_data_in.quotient      = sgn_q_ff;
         out_data_in.quotient_bits = bits[srd_pkg::QBITS_W-1:0];
      end
      out_data_in.divide_by_zero = sgn_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sgn_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         sgn_valid_ff <= in_valid;
         out_valid_ff <= sgn_valid_ff;
      end
      if (en) begin
         sgn_q_ff    <= sgn_q_in;
         sgn_dz_ff   <= in_data.dz;
         out_data_ff <= out_data_in;
      end
   end

endmodule

/* sv/signed_restoring_divider.sv */
// Top level of the signed restoring divider: input stage, one restoring
// step per pipeline stage, then sign and bit-length stages.
// Depends on srd_pkg, srd_prep, srd_div_stage and srd_post.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    srd_pkg::req_type (dividend, divisor)
//   rsp_      out         rsp_valid/rsp_ready    srd_pkg::rsp_type (quotient, bits, flag)
//
// One request is accepted per cycle unless the pipeline is stalled. Its response passes
// through one input register, one register per quotient bit and two output registers.
// Reset clears the valid bits of every stage; data registers are not reset.
// A response held by rsp_ready low freezes the whole pipeline, and req_ready
// falls with it, so nothing is lost or repeated.
module signed_restoring_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srd_pkg::rsp_type  rsp_data
);

   logic               advance;
   logic               valid_chain [srd_pkg::DATA_W+1];
   srd_pkg::stage_type data_chain  [srd_pkg::DATA_W+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   srd_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (req_valid),
      .in_data      (req_data),
      .out_valid_ff (valid_chain[0]),
      .out_data_ff  (data_chain[0])
   );

   for (genvar g = 0; g < srd_pkg::DATA_W; g++) begin : g_step
      srd_div_stage u_step (
         .clock        (clock),
         .reset        (reset),
         .en           (advance),
         .in_valid     (valid_chain[g]),
         .in_data      (data_chain[g]),
         .out_valid_ff (valid_chain[g+1]),
         .out_data_ff  (data_chain[g+1])
      );
   end

   srd_post u_post (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (valid_chain[srd_pkg::DATA_W]),
      .in_data      (data_chain[srd_pkg::DATA_W]),
      .out_valid_ff (rsp_valid),
      .out_data_ff  (rsp_data)
   );

   a_dz_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         rsp_data.quotient == '0 && rsp_data.quotient_bits == '0)
      else $error("Divide by zero response carries a nonzero quotient.");

   a_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.quotient == '0) == (rsp_data.quotient_bits == '0)))
      else $error("Quotient bit length disagrees with a zero quotient.");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.quotient_bits <=
         srd_pkg::QBITS_W'(srd_pkg::DATA_W > srd_pkg::QBITS_MAX ?
                           srd_pkg::QBITS_MAX : srd_pkg::DATA_W))
      else $error("Quotient bit length exceeds the data width.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Request taken while the pipeline is stalled.");

   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.quotient_bits == srd_pkg::QBITS_W'(1) |->
         rsp_data.quotient == '1)
      else $error("A one-bit quotient must be minus one.");

endmodule

/* verif/quotient_checker.sv */
// Checker for the signed restoring divider: predicts the quotient of every
// accepted request, compares each accepted response and counts failures.
// Depends on srd_pkg.
`timescale 1ns / 100ps

module quotient_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  srd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  srd_pkg::rsp_type rsp_data,
   output int               failures,
   output int               outstanding
);

   srd_pkg::rsp_type expected_quotients[$];
   int               mismatch_count = 0;
   int               checked_count  = 0;

   function automatic srd_pkg::rsp_type signed_divide(input srd_pkg::req_type r);
      logic [srd_pkg::DATA_W-1:0] a_bits;
      logic [srd_pkg::DATA_W-1:0] b_bits;
      logic [srd_pkg::DATA_W-1:0] mag_a;
      logic [srd_pkg::DATA_W-1:0] mag_b;
      logic [srd_pkg::DATA_W:0]   partial;
      logic [srd_pkg::DATA_W-1:0] quo;
      logic [srd_pkg::DATA_W-1:0] q;
      logic [srd_pkg::DATA_W-1:0] folded;
      int unsigned                len;
      srd_pkg::rsp_type           res;
      res    = '0;
      a_bits = r.dividend;
      b_bits = r.divisor;
      if (b_bits == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      mag_a   = a_bits[srd_pkg::DATA_W-1] ? (~a_bits + 1'b1) : a_bits;
      mag_b   = b_bits[srd_pkg::DATA_W-1] ? (~b_bits + 1'b1) : b_bits;
      partial = '0;
      quo     = '0;
      for (int i = srd_pkg::DATA_W - 1; i >= 0; i--) begin
         partial = {partial[srd_pkg::DATA_W-1:0], mag_a[i]};
         quo     = {quo[srd_pkg::DATA_W-2:0], 1'b0};
         if (partial >= {1'b0, mag_b}) begin
            partial = partial - {1'b0, mag_b};
            quo[0]  = 1'b1;
         end
      end
      q = (a_bits[srd_pkg::DATA_W-1] ^ b_bits[srd_pkg::DATA_W-1]) ? (~quo + 1'b1) : quo;
      if (q == '0) begin
         len = 0;
      end else begin
         folded = q[srd_pkg::DATA_W-1] ? ~q : q;
         len    = 1;
         while (folded != '0) begin
            len++;
            folded = folded >> 1;
         end
      end
      if (len > srd_pkg::QBITS_MAX) begin
         len = srd_pkg::QBITS_MAX;
      end
      res.quotient      = q;
      res.quotient_bits = len[srd_pkg::QBITS_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      srd_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_quotients.push_back(signed_divide(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (expected_quotients.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response %0d arrived with no request pending: quotient %0d",
                           checked_count, rsp_data.quotient);
               end
            end else begin
               want = expected_quotients.pop_front();
               if (rsp_data.quotient !== want.quotient
                   || rsp_data.quotient_bits !== want.quotient_bits
                   || rsp_data.divide_by_zero !== want.divide_by_zero) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("response %0d: quotient exp %0d got %0d, bits exp %0d got %0d, %s",
                              checked_count, want.quotient, rsp_data.quotient,
                              want.quotient_bits, rsp_data.quotient_bits,
                              $sformatf("divide_by_zero exp %0b got %0b",
                                        want.divide_by_zero, rsp_data.divide_by_zero));
                  end
               end
            end
         end
      end
      failures    <= mismatch_count;
      outstanding <= expected_quotients.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the divider testbench: clock, reset, request and response drivers,
// watchdog and verdict. Depends on srd_pkg, signed_restoring_divider and
// quotient_checker.
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = srd_pkg::DATA_W + 10;
   localparam int PHASE_ITEMS    = 490;
   localparam logic [srd_pkg::DATA_W-1:0] MIN_WORD  = {1'b1, {(srd_pkg::DATA_W-1){1'b0}}};
   localparam logic [srd_pkg::DATA_W-1:0] MAX_WORD  = ~MIN_WORD;
   localparam logic [srd_pkg::DATA_W-1:0] MINUS_ONE = '1;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   srd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   srd_pkg::rsp_type rsp_data;
   int               failures;
   int               outstanding;
   int               idle_pct;
   int               stall_pct;
   int               quiet_cycles;

   signed_restoring_divider u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   quotient_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [srd_pkg::DATA_W-1:0] a,
                               input logic [srd_pkg::DATA_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data.dividend <= a;
      req_data.divisor  <= b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic send_random;
      logic [srd_pkg::DATA_W-1:0] a;
      logic [srd_pkg::DATA_W-1:0] b;
      logic signed [7:0]          narrow;
      a      = $urandom;
      b      = $urandom;
      narrow = 8'($urandom_range(255));
      case ($urandom_range(9))
         3: begin
            a = $urandom_range(600) - 300;
            b = $urandom_range(40) - 20;
         end
         4: b = {{(srd_pkg::DATA_W-8){narrow[7]}}, narrow};
         5: b = '0;
         6: begin
            a = MIN_WORD;
            case ($urandom_range(3))
               0: b = MINUS_ONE;
               1: b = 1;
               2: b = MIN_WORD;
               default: ;
            endcase
         end
         7: begin
            b = 1 << $urandom_range(srd_pkg::DATA_W - 1);
            if ($urandom_range(1) == 1) begin
               b = ~b + 1'b1;
            end
         end
         8: a = $signed(a) >>> $urandom_range(srd_pkg::DATA_W - 1);
         9: b = $signed(b) >>> $urandom_range(srd_pkg::DATA_W - 1);
         default: ;
      endcase
      send_request(a, b);
   endtask

   initial begin
      int idle_plan[4];
      int stall_plan[4];
      idle_plan  = '{0, 67, 0, 25};
      stall_plan = '{0, 0, 67, 25};
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      idle_pct   = 0;
      stall_pct  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(0, 1);
      send_request(MAX_WORD, 1);
      send_request(MIN_WORD, 1);
      send_request(MIN_WORD, MINUS_ONE);
      send_request(MAX_WORD, MINUS_ONE);
      send_request(MIN_WORD, MIN_WORD);
      send_request(MAX_WORD, MAX_WORD);
      send_request(MAX_WORD, MIN_WORD);
      send_request(MIN_WORD, MAX_WORD);
      send_request(5, 0);
      send_request(0, 0);
      send_request(MIN_WORD, 0);
      send_request(MINUS_ONE, 0);
      send_request(-7, 2);
      send_request(7, -2);
      send_request(-7, -2);
      send_request(1, MAX_WORD);
      send_request(MINUS_ONE, MIN_WORD);
      send_request(MIN_WORD, 2);
      send_request(100, 7);
      send_request(MAX_WORD, -3);
      send_request(MINUS_ONE, 1);
      send_request(3, 4);

      for (int p = 0; p < 4; p++) begin
         drain();
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/srd_pkg.sv
sv/srd_prep.sv
sv/srd_div_stage.sv
sv/srd_post.sv
sv/signed_restoring_divider.sv
verif/quotient_checker.sv
verif/testbench.sv
